// File: hdl/cbo_pkg.sv
// Shared types and constants for the cubic Bezier offset point pipeline.
package cbo_pkg;

    localparam int CW       = 24;  // coordinate width, Q16.8
    localparam int TW       = 17;  // curve parameter width, Q1.16
    localparam int KW       = 28;  // power basis coefficient width
    localparam int PW       = 25;  // curve point width before saturation
    localparam int DW       = 58;  // tangent component width
    localparam int MW       = 57;  // tangent magnitude width
    localparam int NW       = 30;  // normalized magnitude width
    localparam int VW       = 61;  // sum of squares width
    localparam int LW       = 31;  // tangent length width
    localparam int RW       = 64;  // square root working width
    localparam int NMW      = 47;  // dividend width
    localparam int QW       = 16;  // quotient width
    localparam int MSBW     = 6;   // width of a bit position in a magnitude
    localparam int NORM_MSB = 29;  // target leading one position after normalizing

    localparam logic [TW-1:0] T_ONE = 17'd65536;

    typedef struct packed {
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] p3_x;
        logic signed [CW-1:0] p3_y;
        logic signed [CW-1:0] p4_x;
        logic signed [CW-1:0] p4_y;
        logic [TW-1:0]        param_t;
        logic                 inward;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] off_x;
        logic signed [CW-1:0] off_y;
        logic                 zero_tangent;
    } t_out;

    // Power basis coefficients of one axis, plus the tangent terms.
    typedef struct packed {
        logic signed [CW-1:0] a0;
        logic signed [KW-1:0] a1;
        logic signed [KW-1:0] a2;
        logic signed [KW-1:0] a3;
        logic signed [PW-1:0] d1;
        logic signed [PW:0]   e1;
        logic signed [PW-1:0] dir;
    } t_coef;

    typedef struct packed {
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] cy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 inward;
    } t_poly;

    typedef struct packed {
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] cy;
        logic                 zero;
        logic                 inward;
        logic                 neg_x;
        logic                 neg_y;
    } t_side;

    typedef struct packed {
        t_side         side;
        logic [NW-1:0] ax;
        logic [NW-1:0] ay;
    } t_vec;

endpackage

// File: hdl/cbo_poly.sv
// Curve point and tangent evaluation by Horner steps in the power basis.
module cbo_poly (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbo_pkg::t_in   i_item,
    output logic           o_valid,
    output cbo_pkg::t_poly o_poly
);
    import cbo_pkg::*;

    function automatic t_coef calc_coef(input logic signed [CW-1:0] p1,
                                        input logic signed [CW-1:0] p2,
                                        input logic signed [CW-1:0] p3,
                                        input logic signed [CW-1:0] p4);
        logic signed [KW-1:0] q1;
        logic signed [KW-1:0] q2;
        logic signed [KW-1:0] q3;
        logic signed [KW-1:0] q4;
        t_coef c;
        q1 = KW'(p1);
        q2 = KW'(p2);
        q3 = KW'(p3);
        q4 = KW'(p4);
        c.a0  = p1;
        c.a1  = KW'(3 * (q2 - q1));
        c.a2  = KW'(3 * (q1 - 2 * q2 + q3));
        c.a3  = KW'(q4 - 3 * q3 + 3 * q2 - q1);
        c.d1  = PW'(q2 - q1);
        c.e1  = (PW+1)'((q3 - q2) - (q2 - q1));
        c.dir = PW'(q3 - q1);
        return c;
    endfunction

    // Stage A: clamp t and form the coefficients.
    logic          n_a_coin;
    logic [TW-1:0] n_a_t;
    logic          r_a_vld;
    logic [TW-1:0] r_a_t;
    t_coef         r_a_cx;
    t_coef         r_a_cy;
    logic          r_a_coin;
    logic          r_a_inward;

    assign n_a_t    = (i_item.param_t > T_ONE) ? T_ONE : i_item.param_t;
    assign n_a_coin = (i_item.p1_x == i_item.p2_x) && (i_item.p1_y == i_item.p2_y) &&
                      (i_item.p3_x == i_item.p4_x) && (i_item.p3_y == i_item.p4_y);

    // Stage B: first Horner step, the a3 * t product is shared.
    logic signed [TW:0]       a_ts;
    logic signed [KW+TW:0]    b_m3x;
    logic signed [KW+TW:0]    b_m3y;
    logic signed [KW+TW+1:0]  n_b_h1x;
    logic signed [KW+TW+1:0]  n_b_h1y;
    logic signed [KW+TW+1:0]  n_b_g1x;
    logic signed [KW+TW+1:0]  n_b_g1y;
    logic                     r_b_vld;
    logic [TW-1:0]            r_b_t;
    t_coef                    r_b_cx;
    t_coef                    r_b_cy;
    logic                     r_b_coin;
    logic                     r_b_inward;
    logic signed [KW+TW+1:0]  r_b_h1x;
    logic signed [KW+TW+1:0]  r_b_h1y;
    logic signed [KW+TW+1:0]  r_b_g1x;
    logic signed [KW+TW+1:0]  r_b_g1y;

    assign a_ts    = $signed({1'b0, r_a_t});
    assign b_m3x   = r_a_cx.a3 * a_ts;
    assign b_m3y   = r_a_cy.a3 * a_ts;
    assign n_b_h1x = (KW+TW+2)'(b_m3x) + ((KW+TW+2)'(r_a_cx.a2) <<< 16);
    assign n_b_h1y = (KW+TW+2)'(b_m3y) + ((KW+TW+2)'(r_a_cy.a2) <<< 16);
    assign n_b_g1x = (KW+TW+2)'(b_m3x) + ((KW+TW+2)'(r_a_cx.e1) <<< 17);
    assign n_b_g1y = (KW+TW+2)'(b_m3y) + ((KW+TW+2)'(r_a_cy.e1) <<< 17);

    // Stage C: second Horner step, tangent is complete here.
    logic signed [TW:0]         b_ts;
    logic signed [64:0]         c_phx;
    logic signed [64:0]         c_phy;
    logic signed [64:0]         c_pgx;
    logic signed [64:0]         c_pgy;
    logic signed [64:0]         c_sx;
    logic signed [64:0]         c_sy;
    logic signed [64:0]         c_gx;
    logic signed [64:0]         c_gy;
    logic signed [DW-1:0]       n_c_dx;
    logic signed [DW-1:0]       n_c_dy;
    logic                       r_c_vld;
    logic [TW-1:0]              r_c_t;
    logic signed [CW-1:0]       r_c_a0x;
    logic signed [CW-1:0]       r_c_a0y;
    logic                       r_c_inward;
    logic signed [62:0]         r_c_h2x;
    logic signed [62:0]         r_c_h2y;
    logic signed [DW-1:0]       r_c_dx;
    logic signed [DW-1:0]       r_c_dy;

    assign b_ts   = $signed({1'b0, r_b_t});
    assign c_phx  = r_b_h1x * b_ts;
    assign c_phy  = r_b_h1y * b_ts;
    assign c_pgx  = r_b_g1x * b_ts;
    assign c_pgy  = r_b_g1y * b_ts;
    assign c_sx   = c_phx + (65'(r_b_cx.a1) <<< 32);
    assign c_sy   = c_phy + (65'(r_b_cy.a1) <<< 32);
    assign c_gx   = c_pgx + (65'(r_b_cx.d1) <<< 32);
    assign c_gy   = c_pgy + (65'(r_b_cy.d1) <<< 32);
    // Coincident end pairs use the chord from the first to the third point.
    assign n_c_dx = r_b_coin ? DW'(r_b_cx.dir) : c_gx[DW-1:0];
    assign n_c_dy = r_b_coin ? DW'(r_b_cy.dir) : c_gy[DW-1:0];

    // Stage D: last Horner step and rounding of the curve point.
    logic signed [TW:0]   c_ts;
    logic signed [80:0]   d_px;
    logic signed [80:0]   d_py;
    logic signed [80:0]   d_sx;
    logic signed [80:0]   d_sy;

    assign c_ts = $signed({1'b0, r_c_t});
    assign d_px = r_c_h2x * c_ts;
    assign d_py = r_c_h2y * c_ts;
    assign d_sx = d_px + (81'(r_c_a0x) <<< 48) + (81'(1) <<< 47);
    assign d_sy = d_py + (81'(r_c_a0y) <<< 48) + (81'(1) <<< 47);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            o_valid <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_t      <= n_a_t;
        r_a_cx     <= calc_coef(i_item.p1_x, i_item.p2_x, i_item.p3_x, i_item.p4_x);
        r_a_cy     <= calc_coef(i_item.p1_y, i_item.p2_y, i_item.p3_y, i_item.p4_y);
        r_a_coin   <= n_a_coin;
        r_a_inward <= i_item.inward;

        r_b_t      <= r_a_t;
        r_b_cx     <= r_a_cx;
        r_b_cy     <= r_a_cy;
        r_b_coin   <= r_a_coin;
        r_b_inward <= r_a_inward;
        r_b_h1x    <= n_b_h1x;
        r_b_h1y    <= n_b_h1y;
        r_b_g1x    <= n_b_g1x;
        r_b_g1y    <= n_b_g1y;

        r_c_t      <= r_b_t;
        r_c_a0x    <= r_b_cx.a0;
        r_c_a0y    <= r_b_cy.a0;
        r_c_inward <= r_b_inward;
        r_c_h2x    <= c_sx[62:0];
        r_c_h2y    <= c_sy[62:0];
        r_c_dx     <= n_c_dx;
        r_c_dy     <= n_c_dy;

        o_poly.cx     <= d_sx[48+PW-1:48];
        o_poly.cy     <= d_sy[48+PW-1:48];
        o_poly.dx     <= r_c_dx;
        o_poly.dy     <= r_c_dy;
        o_poly.inward <= r_c_inward;
    end

endmodule

// File: hdl/cbo_norm.sv
// Tangent magnitude normalization and sum of squares.
module cbo_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbo_pkg::t_poly i_poly,
    output logic           o_valid,
    output cbo_pkg::t_vec  o_vec,
    output logic [cbo_pkg::VW-1:0] o_sumsq
);
    import cbo_pkg::*;

    logic [MW-1:0]   n_e_ax;
    logic [MW-1:0]   n_e_ay;
    t_side           n_e_side;
    logic            r_e_vld;
    logic [MW-1:0]   r_e_ax;
    logic [MW-1:0]   r_e_ay;
    t_side           r_e_side;

    logic [MW-1:0]   f_or;
    logic [MSBW-1:0] n_f_msb;
    logic            r_f_vld;
    logic [MW-1:0]   r_f_ax;
    logic [MW-1:0]   r_f_ay;
    logic [MSBW-1:0] r_f_msb;
    t_side           r_f_side;

    logic [NW-1:0]   n_g_ax;
    logic [NW-1:0]   n_g_ay;
    logic            r_g_vld;
    logic [NW-1:0]   r_g_ax;
    logic [NW-1:0]   r_g_ay;
    t_side           r_g_side;

    logic            r_h_vld;
    logic [NW-1:0]   r_h_ax;
    logic [NW-1:0]   r_h_ay;
    logic [2*NW-1:0] r_h_sqx;
    logic [2*NW-1:0] r_h_sqy;
    t_side           r_h_side;

    // Stage E: magnitudes, signs and the zero test.
    always_comb begin
        n_e_ax        = i_poly.dx[DW-1] ? MW'(-i_poly.dx) : MW'(i_poly.dx);
        n_e_ay        = i_poly.dy[DW-1] ? MW'(-i_poly.dy) : MW'(i_poly.dy);
        n_e_side.cx     = i_poly.cx;
        n_e_side.cy     = i_poly.cy;
        n_e_side.zero   = (i_poly.dx == '0) && (i_poly.dy == '0);
        n_e_side.inward = i_poly.inward;
        n_e_side.neg_x  = i_poly.dx[DW-1];
        n_e_side.neg_y  = i_poly.dy[DW-1];
    end

    // Stage F: position of the leading one of the larger magnitude.
    assign f_or = r_e_ax | r_e_ay;

    always_comb begin
        n_f_msb = '0;
        for (int i = 0; i < MW; i++) begin
            if (f_or[i]) begin
                n_f_msb = MSBW'(i);
            end
        end
    end

    // Stage G: shift both magnitudes so the larger leads at NORM_MSB.
    always_comb begin
        if (r_f_msb >= MSBW'(NORM_MSB)) begin
            n_g_ax = NW'(r_f_ax >> (r_f_msb - MSBW'(NORM_MSB)));
            n_g_ay = NW'(r_f_ay >> (r_f_msb - MSBW'(NORM_MSB)));
        end else begin
            n_g_ax = NW'(r_f_ax << (MSBW'(NORM_MSB) - r_f_msb));
            n_g_ay = NW'(r_f_ay << (MSBW'(NORM_MSB) - r_f_msb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_e_vld <= i_valid;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            o_valid <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ax   <= n_e_ax;
        r_e_ay   <= n_e_ay;
        r_e_side <= n_e_side;

        r_f_ax   <= r_e_ax;
        r_f_ay   <= r_e_ay;
        r_f_msb  <= n_f_msb;
        r_f_side <= r_e_side;

        r_g_ax   <= n_g_ax;
        r_g_ay   <= n_g_ay;
        r_g_side <= r_f_side;

        r_h_ax   <= r_g_ax;
        r_h_ay   <= r_g_ay;
        r_h_sqx  <= r_g_ax * r_g_ax;
        r_h_sqy  <= r_g_ay * r_g_ay;
        r_h_side <= r_g_side;

        o_vec.side <= r_h_side;
        o_vec.ax   <= r_h_ax;
        o_vec.ay   <= r_h_ay;
        o_sumsq    <= VW'(r_h_sqx) + VW'(r_h_sqy);
    end

endmodule

// File: hdl/cbo_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cbo_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [cbo_pkg::VW-1:0] i_sumsq,
    input  cbo_pkg::t_vec          i_vec,
    output logic                   o_valid,
    output logic [cbo_pkg::LW-1:0] o_root,
    output cbo_pkg::t_vec          o_vec
);
    import cbo_pkg::*;

    localparam int STEPS = RW / 2;

    logic          r_vld [STEPS];
    logic [RW-1:0] r_v   [STEPS];
    logic [RW-1:0] r_r   [STEPS];
    t_vec          r_pl  [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic          vld_in;
        logic [RW-1:0] v_in;
        logic [RW-1:0] r_in;
        t_vec          pl_in;
        logic [RW-1:0] bit_c;
        logic [RW-1:0] trial;

        if (s == 0) begin : g_first
            assign vld_in = i_valid;
            assign v_in   = RW'(i_sumsq);
            assign r_in   = '0;
            assign pl_in  = i_vec;
        end else begin : g_next
            assign vld_in = r_vld[s-1];
            assign v_in   = r_v[s-1];
            assign r_in   = r_r[s-1];
            assign pl_in  = r_pl[s-1];
        end

        assign bit_c = RW'(1) << (2 * (STEPS - 1 - s));
        assign trial = r_in + bit_c;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_pl[s] <= pl_in;
            if (v_in >= trial) begin
                r_v[s] <= v_in - trial;
                r_r[s] <= (r_in >> 1) + bit_c;
            end else begin
                r_v[s] <= v_in;
                r_r[s] <= r_in >> 1;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_r[STEPS-1][LW-1:0];
    assign o_vec   = r_pl[STEPS-1];

endmodule

// File: hdl/cbo_div.sv
// Scaling by the offset distance and pipelined rounded division by the length.
module cbo_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [cbo_pkg::LW-1:0] i_root,
    input  cbo_pkg::t_vec          i_vec,
    input  logic [cbo_pkg::QW-1:0] i_dist,
    output logic                   o_valid,
    output logic [cbo_pkg::QW-1:0] o_qx,
    output logic [cbo_pkg::QW-1:0] o_qy,
    output cbo_pkg::t_side         o_side
);
    import cbo_pkg::*;

    logic           r_vld [QW+1];
    logic [NMW-1:0] r_rx  [QW+1];
    logic [NMW-1:0] r_ry  [QW+1];
    logic [QW-1:0]  r_qx  [QW+1];
    logic [QW-1:0]  r_qy  [QW+1];
    logic [LW-1:0]  r_len [QW+1];
    t_side          r_pl  [QW+1];

    // Entry stage: dividend is magnitude times distance plus half the length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx[0]  <= NMW'(i_vec.ax) * NMW'(i_dist) + NMW'(i_root >> 1);
        r_ry[0]  <= NMW'(i_vec.ay) * NMW'(i_dist) + NMW'(i_root >> 1);
        r_qx[0]  <= '0;
        r_qy[0]  <= '0;
        r_len[0] <= i_root;
        r_pl[0]  <= i_vec.side;
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [NMW-1:0] dsh;

        assign dsh = NMW'(r_len[s]) << (QW - 1 - s);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_len[s+1] <= r_len[s];
            r_pl[s+1]  <= r_pl[s];
            if (r_rx[s] >= dsh) begin
                r_rx[s+1] <= r_rx[s] - dsh;
                r_qx[s+1] <= {r_qx[s][QW-2:0], 1'b1};
            end else begin
                r_rx[s+1] <= r_rx[s];
                r_qx[s+1] <= {r_qx[s][QW-2:0], 1'b0};
            end
            if (r_ry[s] >= dsh) begin
                r_ry[s+1] <= r_ry[s] - dsh;
                r_qy[s+1] <= {r_qy[s][QW-2:0], 1'b1};
            end else begin
                r_ry[s+1] <= r_ry[s];
                r_qy[s+1] <= {r_qy[s][QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_qx    = r_qx[QW];
    assign o_qy    = r_qy[QW];
    assign o_side  = r_pl[QW];

endmodule

// File: hdl/cubic_bezier_offset_point.sv
// Top level of the cubic Bezier normal offset point pipeline.
//
// Each item carries four control points, a parameter t and an offset side, and
// yields exactly one result: the curve point moved along the unit normal by
// the programmed offset distance. An item is taken at every clock edge with
// start high; busy is always low, so a new item may follow in every cycle.
// The item passes 59 register stages, counting the one that takes it, and its
// result is on o_result with o_done high for a single cycle, in the order the
// items came in. The receiver cannot hold results back, so it must take each
// one when o_done is high. The pipeline depth is made up of four Horner stages
// for the curve point and tangent, five for normalizing, 32 for the square root
// (one root bit per stage), 17 for the scaled division (an entry stage, then
// one quotient bit per stage) and one output stage. When the tangent is zero
// the result is the curve point itself and zero_tangent is set. The offset
// distance register is written through i_cfg_we and i_cfg_wdata and is read by
// the divider entry stage directly, so it should only be changed while no item
// is in flight.
module cubic_bezier_offset_point (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cbo_pkg::t_in           i_item,
    output logic                   o_done,
    output cbo_pkg::t_out          o_result,
    input  logic                   i_cfg_we,
    input  logic [cbo_pkg::QW-1:0] i_cfg_wdata
);
    import cbo_pkg::*;

    localparam logic [QW-1:0] DIST_RESET = 16'd256;
    localparam int            SUMW       = PW + 2;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = SUMW'(8388607);
        lo = -SUMW'(8388608);
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    logic [QW-1:0]  r_offset_distance;

    logic           poly_vld;
    t_poly          poly_data;
    logic           norm_vld;
    t_vec           norm_vec;
    logic [VW-1:0]  norm_sumsq;
    logic           sqrt_vld;
    logic [LW-1:0]  sqrt_root;
    t_vec           sqrt_vec;
    logic           div_vld;
    logic [QW-1:0]  div_qx;
    logic [QW-1:0]  div_qy;
    t_side          div_side;

    logic signed [QW+1:0] nx;
    logic signed [QW+1:0] ny;
    logic signed [QW+1:0] ox;
    logic signed [QW+1:0] oy;
    logic signed [SUMW-1:0] n_rx;
    logic signed [SUMW-1:0] n_ry;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_distance <= DIST_RESET;
        end else if (i_cfg_we) begin
            r_offset_distance <= i_cfg_wdata;
        end
    end

    cbo_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (poly_vld),
        .o_poly  (poly_data)
    );

    cbo_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (poly_vld),
        .i_poly  (poly_data),
        .o_valid (norm_vld),
        .o_vec   (norm_vec),
        .o_sumsq (norm_sumsq)
    );

    cbo_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_vld),
        .i_sumsq (norm_sumsq),
        .i_vec   (norm_vec),
        .o_valid (sqrt_vld),
        .o_root  (sqrt_root),
        .o_vec   (sqrt_vec)
    );

    cbo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_vld),
        .i_root  (sqrt_root),
        .i_vec   (sqrt_vec),
        .i_dist  (r_offset_distance),
        .o_valid (div_vld),
        .o_qx    (div_qx),
        .o_qy    (div_qy),
        .o_side  (div_side)
    );

    // Restore the tangent signs, then rotate a quarter turn. An inner offset
    // turns clockwise to (ty, -tx); an outer one turns to (-ty, tx).
    always_comb begin
        nx = div_side.neg_x ? -$signed({2'b00, div_qx}) : $signed({2'b00, div_qx});
        ny = div_side.neg_y ? -$signed({2'b00, div_qy}) : $signed({2'b00, div_qy});
        if (div_side.inward) begin
            ox = ny;
            oy = -nx;
        end else begin
            ox = -ny;
            oy = nx;
        end
        if (div_side.zero) begin
            n_rx = SUMW'(div_side.cx);
            n_ry = SUMW'(div_side.cy);
        end else begin
            n_rx = SUMW'(div_side.cx) + SUMW'(ox);
            n_ry = SUMW'(div_side.cy) + SUMW'(oy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.off_x        <= sat_coord(n_rx);
        o_result.off_y        <= sat_coord(n_ry);
        o_result.zero_tangent <= div_side.zero;
    end

endmodule

// File: sim/cubic_bezier_offset_point_tb.sv
// Self-checking testbench for the cubic Bezier normal offset point pipeline.
`timescale 1ns / 100ps

module cubic_bezier_offset_point_tb;
    import cbo_pkg::*;

    localparam int LATENCY    = 59;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_LOUD   = 10;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in              i_item;
    logic             o_done;
    t_out             o_result;
    logic             i_cfg_we;
    logic [QW-1:0]    i_cfg_wdata;

    // Expected offset points, oldest first.
    t_out             offset_points_due[$];
    // Local copy of the offset distance register.
    logic [15:0]      distance_q88;
    int               mismatches;
    int               idle_cycles;
    bit               quiet_stretch;

    cubic_bezier_offset_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounds a weighted sum with 48 extra fraction bits to Q16.8, halves toward
    // plus infinity.
    function automatic logic signed [127:0] round_q48(input logic signed [127:0] acc);
        logic signed [127:0] biased;
        begin
            biased = acc + (128'sd1 <<< 47);
            return biased >>> 48;
        end
    endfunction

    function automatic logic signed [23:0] clamp24(input logic signed [127:0] v);
        if (v > 128'sd8388607) return 24'sh7FFFFF;
        if (v < -128'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        begin
            root = 0;
            rem  = v;
            bitv = 64'd1 << 62;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        end
    endfunction

    // Works out the offset point that one item must produce.
    function automatic t_out offset_point(input t_in it);
        logic signed [127:0] px [4];
        logic signed [127:0] py [4];
        logic signed [127:0] w [4];
        logic signed [127:0] cx, cy, dx, dy, a2, ab, b2, ox, oy, nx, ny;
        logic [127:0]        ax, ay, peak, len, qx, qy;
        logic [127:0]        t, u;
        t_out                r;
        begin
            px[0] = it.p1_x; py[0] = it.p1_y;
            px[1] = it.p2_x; py[1] = it.p2_y;
            px[2] = it.p3_x; py[2] = it.p3_y;
            px[3] = it.p4_x; py[3] = it.p4_y;
            t = (it.param_t > T_ONE) ? 128'd65536 : 128'(it.param_t);
            u = 128'd65536 - t;
            w[0] = u * u * u;
            w[1] = 3 * u * u * t;
            w[2] = 3 * u * t * t;
            w[3] = t * t * t;
            cx = 0;
            cy = 0;
            for (int i = 0; i < 4; i++) begin
                cx += px[i] * w[i];
                cy += py[i] * w[i];
            end
            // The weights are Q1.48 and coordinates Q16.8; keep Q16.8.
            cx = round_q48(cx);
            cy = round_q48(cy);
            // Coincident control pairs use the chord from P1 to P3.
            if (px[0] == px[1] && py[0] == py[1] && px[2] == px[3] && py[2] == py[3]) begin
                dx = px[2] - px[0];
                dy = py[2] - py[0];
            end else begin
                a2 = u * u;
                ab = 2 * u * t;
                b2 = t * t;
                dx = a2 * (px[1] - px[0]) + ab * (px[2] - px[1]) + b2 * (px[3] - px[2]);
                dy = a2 * (py[1] - py[0]) + ab * (py[2] - py[1]) + b2 * (py[3] - py[2]);
            end
            r.zero_tangent = (dx == 0 && dy == 0);
            ox = 0;
            oy = 0;
            if (!r.zero_tangent) begin
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                peak = (ax > ay) ? ax : ay;
                while (peak >= (128'd1 << 30)) begin
                    ax = ax >> 1; ay = ay >> 1; peak = peak >> 1;
                end
                while (peak < (128'd1 << 29)) begin
                    ax = ax << 1; ay = ay << 1; peak = peak << 1;
                end
                len = floor_sqrt(64'(ax * ax + ay * ay));
                qx = (ax * distance_q88 + (len >> 1)) / len;
                qy = (ay * distance_q88 + (len >> 1)) / len;
                nx = (dx < 0) ? -$signed(qx) : $signed(qx);
                ny = (dy < 0) ? -$signed(qy) : $signed(qy);
                if (it.inward) begin
                    ox = ny; oy = -nx;
                end else begin
                    ox = -ny; oy = nx;
                end
            end
            r.off_x = clamp24(cx + ox);
            r.off_y = clamp24(cy + oy);
            return r;
        end
    endfunction

    // Result checker: the block strobes each result for one cycle only.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (offset_points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_LOUD)
                    $display("unexpected result x=%0d y=%0d z=%0b",
                             o_result.off_x, o_result.off_y, o_result.zero_tangent);
            end else begin
                want = offset_points_due.pop_front();
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_LOUD)
                        $display("result mismatch: expected x=%0d y=%0d z=%0b, got x=%0d y=%0d z=%0b",
                                 want.off_x, want.off_y, want.zero_tangent,
                                 o_result.off_x, o_result.off_y, o_result.zero_tangent);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no item and no result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sends one item, with an occasional random gap first, and records its result.
    task automatic send_item(input t_in it);
        if (!quiet_stretch && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        offset_points_due.push_back(offset_point(it));
    endtask

    // Lowers start and waits for the pipeline to drain.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (offset_points_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_distance(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        distance_q88 = value;
    endtask

    function automatic logic signed [23:0] any_coord();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in random_curve();
        t_in it;
        it.p1_x = any_coord(); it.p1_y = any_coord();
        it.p2_x = any_coord(); it.p2_y = any_coord();
        it.p3_x = any_coord(); it.p3_y = any_coord();
        it.p4_x = any_coord(); it.p4_y = any_coord();
        case ($urandom_range(9))
            0: it.param_t = 17'd0;
            1: it.param_t = T_ONE;
            2: it.param_t = 17'($urandom_range(131071, 65537));
            default: it.param_t = 17'($urandom_range(65536));
        endcase
        it.inward = 1'($urandom_range(1));
        // Some curves get coincident pairs or a degenerate single point.
        case ($urandom_range(11))
            0: begin
                it.p2_x = it.p1_x; it.p2_y = it.p1_y;
                it.p4_x = it.p3_x; it.p4_y = it.p3_y;
            end
            1: begin
                it.p2_x = it.p1_x; it.p2_y = it.p1_y;
                it.p3_x = it.p1_x; it.p3_y = it.p1_y;
                it.p4_x = it.p1_x; it.p4_y = it.p1_y;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Directed items: extremes, both sides, coincident pairs, zero tangent, oversized t.
    task automatic test_directed;
        t_in it;
        it = '0;
        it.p2_x = 24'sd256; it.p3_x = 24'sd512; it.p4_x = 24'sd768;
        for (int s = 0; s < 2; s++) begin
            it.inward  = 1'(s);
            it.param_t = 17'd32768;
            send_item(it);
            it.param_t = 17'd0;
            send_item(it);
            it.param_t = T_ONE;
            send_item(it);
            it.param_t = 17'h1FFFF;
            send_item(it);
        end
        // Coincident pairs.
        it = '0;
        it.p1_x = 24'sd100; it.p2_x = 24'sd100;
        it.p3_y = 24'sd300; it.p4_y = 24'sd300;
        it.param_t = 17'd1000;
        send_item(it);
        // All points equal: zero tangent.
        it = '0;
        it.p1_x = 24'sd77; it.p2_x = 24'sd77; it.p3_x = 24'sd77; it.p4_x = 24'sd77;
        it.p1_y = -24'sd5; it.p2_y = -24'sd5; it.p3_y = -24'sd5; it.p4_y = -24'sd5;
        send_item(it);
        // Extreme corners and saturation.
        it.p1_x = 24'sh7FFFFF; it.p1_y = 24'sh7FFFFF;
        it.p2_x = 24'sh800000; it.p2_y = 24'sh800000;
        it.p3_x = 24'sh7FFFFF; it.p3_y = 24'sh800000;
        it.p4_x = 24'sh7FFFFF; it.p4_y = 24'sh7FFFFF;
        it.param_t = T_ONE; it.inward = 1'b0;
        send_item(it);
        it.inward = 1'b1; it.param_t = 17'd1;
        send_item(it);
        it.p1_x = 24'sh7FFFFF; it.p2_x = 24'sh7FFFFF; it.p3_x = 24'sh7FFFFF; it.p4_x = 24'sh7FFFFF;
        it.p1_y = 24'sd0; it.p2_y = 24'sd0; it.p3_y = 24'sd256; it.p4_y = 24'sd512;
        it.param_t = 17'd65535;
        send_item(it);
        it.inward = 1'b0;
        send_item(it);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            quiet_stretch = (n >= count / 3) && (n < count / 2);
            send_item(random_curve());
        end
        quiet_stretch = 1'b0;
        drain();
    endtask

    // Runs random items under each offset distance, the extremes among them.
    task automatic test_distances;
        logic [15:0] settings [5];
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'($urandom)};
        foreach (settings[k]) begin
            write_distance(settings[k]);
            test_random(240);
        end
        write_distance(16'd256);
        test_random(300);
    endtask

    initial begin
        start         = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        distance_q88  = 16'd256;
        mismatches    = 0;
        idle_cycles   = 0;
        quiet_stretch = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        test_distances();
        if (mismatches == 0 && offset_points_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cbo_pkg.sv
hdl/cbo_poly.sv
hdl/cbo_norm.sv
hdl/cbo_sqrt.sv
hdl/cbo_div.sv
hdl/cubic_bezier_offset_point.sv
sim/cubic_bezier_offset_point_tb.sv
